@@ src/lrp_pkg.sv @@
`default_nettype none
package lrp_pkg;

  localparam int VALUE_BITS = 16;
  localparam int SEED_BITS  = 31;
  localparam int COUNT_BITS = VALUE_BITS + 1;
  localparam int BCNT_BITS  = $clog2(SEED_BITS);
  localparam logic [BCNT_BITS-1:0] SEED_LAST = BCNT_BITS'(SEED_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_MOD_START = 5'b00010,
    S_MOD_OFF   = 5'b00100,
    S_STEP      = 5'b01000,
    S_PUT       = 5'b10000
  } lrp_state_t;

endpackage
`default_nettype wire

@@ src/lrp_req_if.sv @@
`default_nettype none
interface lrp_req_if;
  logic                           valid;
  logic                           ready;
  logic [lrp_pkg::VALUE_BITS-1:0] lower_bound;
  logic [lrp_pkg::VALUE_BITS-1:0] upper_bound;
  logic [lrp_pkg::SEED_BITS-1:0]  seed_start;
  logic [lrp_pkg::SEED_BITS-1:0]  seed_offset;

  modport source (output valid, lower_bound, upper_bound, seed_start, seed_offset,
                  input ready);
  modport sink (input valid, lower_bound, upper_bound, seed_start, seed_offset,
                output ready);
endinterface
`default_nettype wire

@@ src/lrp_res_if.sv @@
`default_nettype none
interface lrp_res_if;
  logic                           valid;
  logic                           ready;
  logic [lrp_pkg::VALUE_BITS-1:0] picked_value;

  modport source (output valid, picked_value, input ready);
  modport sink (input valid, picked_value, output ready);
endinterface
`default_nettype wire

@@ src/lcg_range_permutation.sv @@
`default_nettype none
// channel | dir | fields                                              | handshake
// req     | in  | lower_bound, upper_bound, seed_start, seed_offset   | valid/ready
// res     | out | picked_value                                        | valid/ready
//
// a request with the held bounds runs k lcg steps, k being the steps until a hit
// (under two on average, at most modulus+1)
// a request with new bounds first runs both seeds through the bit-serial remainder unit
// rst is synchronous; after it the first request always runs setup
// the result sits in an output register, so a new request is taken while it waits
module lcg_range_permutation (
  input  logic          clk,
  input  logic          rst,
  lrp_req_if.sink       req,
  lrp_res_if.source     res
);

  localparam int VB = lrp_pkg::VALUE_BITS;
  localparam int CB = lrp_pkg::COUNT_BITS;
  localparam int SB = lrp_pkg::SEED_BITS;
  localparam int NB = lrp_pkg::BCNT_BITS;

  lrp_pkg::lrp_state_t state;

  logic [VB-1:0] held_lower;
  logic [VB-1:0] held_upper;
  logic          set_up_done;
  logic [VB-1:0] current_index;
  logic [CB-1:0] range_count;
  logic [CB-1:0] lcg_multiplier;
  logic [CB-1:0] lcg_increment;
  logic [VB-1:0] modulus_mask;
  logic [SB-1:0] dividend;
  logic [SB-1:0] offset_seed;
  logic [VB-1:0] rem;
  logic [NB-1:0] bit_cnt;
  logic [CB-1:0] step_cnt;
  logic [VB-1:0] result;
  logic          res_valid;
  logic [VB-1:0] res_value;
  logic          put_go;

  // setup values from the incoming bounds
  logic          bounds_bad;
  logic [VB-1:0] norm_lo;
  logic [VB-1:0] norm_hi;
  logic [CB-1:0] norm_count;
  logic [VB-1:0] count_m1;
  logic [VB-1:0] mask_calc;
  logic [CB-1:0] mult_calc;
  logic          need_setup;
  logic          accept;

  assign bounds_bad = req.lower_bound >= req.upper_bound;
  assign norm_lo    = bounds_bad ? '0 : req.lower_bound;
  assign norm_hi    = bounds_bad ? VB'(1) : req.upper_bound;
  assign norm_count = {1'b0, norm_hi} - {1'b0, norm_lo};
  assign count_m1   = norm_count[VB-1:0] - VB'(1);
  assign mult_calc  = {norm_count[CB-1:2], 2'b00} + CB'(1);
  assign need_setup = !set_up_done || (req.lower_bound != held_lower)
                      || (req.upper_bound != held_upper);
  assign accept     = req.valid && (state == lrp_pkg::S_IDLE);
  assign put_go     = (state == lrp_pkg::S_PUT) && (!res_valid || res.ready);

  // smallest power of two at or above the count, minus one
  always_comb begin
    for (int i = 0; i < VB; i++) begin
      mask_calc[i] = |(count_m1 >> i);
    end
  end

  // one remainder bit per cycle against count+1
  logic [CB-1:0] divisor;
  logic [CB-1:0] trial;
  logic [VB-1:0] rem_next;

  assign divisor  = range_count + CB'(1);
  assign trial    = {rem, dividend[SB-1]};
  assign rem_next = (trial >= divisor) ? VB'(trial - divisor) : trial[VB-1:0];

  // lcg step, all in modulus width
  logic [VB-1:0] prod;
  logic [VB-1:0] lcg_next;
  logic          hit;
  logic          last_step;

  assign prod      = VB'(current_index * lcg_multiplier[VB-1:0]);
  assign lcg_next  = (prod + lcg_increment[VB-1:0]) & modulus_mask;
  assign hit       = {1'b0, current_index} < range_count;
  assign last_step = step_cnt == ({1'b0, modulus_mask} + CB'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (put_go) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lrp_pkg::S_IDLE;
      set_up_done <= 1'b0;
      held_lower  <= '0;
      held_upper  <= '0;
    end else begin
      unique case (state)
        lrp_pkg::S_IDLE: begin
          if (accept) begin
            step_cnt <= '0;
            if (need_setup) begin
              held_lower     <= norm_lo;
              held_upper     <= norm_hi;
              range_count    <= norm_count;
              lcg_multiplier <= mult_calc;
              modulus_mask   <= mask_calc;
              set_up_done    <= 1'b1;
              dividend       <= req.seed_start;
              offset_seed    <= req.seed_offset;
              rem            <= '0;
              bit_cnt        <= '0;
              state          <= lrp_pkg::S_MOD_START;
            end else begin
              state <= lrp_pkg::S_STEP;
            end
          end
        end
        lrp_pkg::S_MOD_START: begin
          if (bit_cnt == lrp_pkg::SEED_LAST) begin
            current_index <= rem_next;
            rem           <= '0;
            dividend      <= offset_seed;
            bit_cnt       <= '0;
            state         <= lrp_pkg::S_MOD_OFF;
          end else begin
            rem      <= rem_next;
            dividend <= dividend << 1;
            bit_cnt  <= bit_cnt + NB'(1);
          end
        end
        lrp_pkg::S_MOD_OFF: begin
          rem      <= rem_next;
          dividend <= dividend << 1;
          bit_cnt  <= bit_cnt + NB'(1);
          if (bit_cnt == lrp_pkg::SEED_LAST) begin
            lcg_increment <= {rem_next, 1'b1};
            state         <= lrp_pkg::S_STEP;
          end
        end
        lrp_pkg::S_STEP: begin
          current_index <= lcg_next;
          step_cnt      <= step_cnt + CB'(1);
          if (hit) begin
            result <= current_index + held_lower;
            state  <= lrp_pkg::S_PUT;
          end else if (last_step) begin
            result <= '0;
            state  <= lrp_pkg::S_PUT;
          end
        end
        lrp_pkg::S_PUT: begin
          if (put_go) begin
            res_value <= result;
            state     <= lrp_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lrp_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = state == lrp_pkg::S_IDLE;
  assign res.valid        = res_valid;
  assign res.picked_value = res_value;

endmodule
`default_nettype wire

@@ src/lrp_checker.sv @@
`default_nettype none
module lrp_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           req_valid,
  input wire logic                           req_ready,
  input wire logic                           res_valid,
  input wire logic                           res_ready,
  input wire logic [lrp_pkg::VALUE_BITS-1:0] res_value
);

  // requests taken but not yet answered
  logic [1:0] pending;
  logic       req_acc;
  logic       res_acc;

  assign req_acc = req_valid && req_ready;
  assign res_acc = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_acc) - 2'(res_acc);
    end
  end

  a_reset_clean: assert property (@(posedge clk) rst |=> !res_valid && req_ready)
    else $error("block not idle after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req_ready)
    else $error("request taken while another is in work");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_value))
    else $error("waiting result dropped or changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 2'd0)
    else $error("result without a request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two requests outstanding");

endmodule

bind lcg_range_permutation lrp_checker u_lrp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_value (res.picked_value)
);
`default_nettype wire

@@ dv/lrp_pick_check.sv @@
`default_nettype none
module lrp_pick_check (
  input  logic clk,
  input  logic rst,
  lrp_req_if   req_mon,
  lrp_res_if   res_mon,
  output int   pick_errors,
  output int   picks_outstanding
);

  localparam int VB = lrp_pkg::VALUE_BITS;
  localparam int SB = lrp_pkg::SEED_BITS;
  localparam int CB = lrp_pkg::COUNT_BITS;

  // shuffle state as the block holds it
  bit [VB-1:0] perm_lo;
  bit [VB-1:0] perm_hi;
  bit          perm_ready;
  bit [CB-1:0] perm_idx;
  bit [CB-1:0] perm_cnt;
  bit [CB-1:0] perm_mul;
  bit [CB:0]   perm_inc;
  bit [CB-1:0] perm_mask;

  logic [VB-1:0] picks_due[$];
  logic [VB-1:0] want;
  int            mismatches = 0;

  task automatic report_mismatch(input string what, input logic [VB-1:0] got,
                                 input logic [VB-1:0] exp_val);
    $display("%0t: %s: picked_value %0d, expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  // advances the shuffle by one request and returns the value it yields
  function automatic logic [VB-1:0] next_pick(
      input logic [VB-1:0] lo_in, input logic [VB-1:0] hi_in,
      input logic [SB-1:0] start_seed, input logic [SB-1:0] offset_seed);
    bit [VB-1:0] lo;
    bit [VB-1:0] hi;
    bit [63:0]   span;
    bit [63:0]   modulus;
    bit [63:0]   prod;
    bit [63:0]   n;
    bit [VB-1:0] pick;
    bit          hit;
    lo   = lo_in;
    hi   = hi_in;
    pick = '0;
    hit  = 1'b0;
    // raw bounds are compared, so an inverted request sets up every time
    if (!perm_ready || lo_in != perm_lo || hi_in != perm_hi) begin
      if (lo >= hi) begin
        lo = '0;
        hi = VB'(1);
      end
      perm_lo  = lo;
      perm_hi  = hi;
      span     = 64'(hi) - 64'(lo);
      perm_cnt = CB'(span);
      perm_idx = CB'(64'(start_seed) % (span + 64'd1));
      perm_inc = (CB+1)'((64'(offset_seed) % (span + 64'd1)) * 64'd2 + 64'd1);
      perm_mul = CB'((span & ~64'd3) + 64'd1);
      modulus  = 64'd1;
      while (modulus < span) modulus = modulus << 1;
      perm_mask  = CB'(modulus - 64'd1);
      perm_ready = 1'b1;
    end
    for (n = 0; n <= 64'(perm_mask) + 64'd1; n++) begin
      if (perm_idx < perm_cnt) begin
        pick = VB'(perm_idx + CB'(perm_lo));
        hit  = 1'b1;
      end
      prod     = 64'(perm_idx) * 64'(perm_mul) + 64'(perm_inc);
      perm_idx = CB'(prod & 64'(perm_mask));
      if (hit) break;
    end
    return pick;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      picks_due.delete();
      perm_lo    = '0;
      perm_hi    = '0;
      perm_ready = 1'b0;
      perm_idx   = '0;
      perm_cnt   = '0;
      perm_mul   = '0;
      perm_inc   = '0;
      perm_mask  = '0;
    end else begin
      // a result can never come from the request taken at the same edge
      if (res_mon.valid && res_mon.ready) begin
        if (picks_due.size() == 0) begin
          report_mismatch("result with no request pending", res_mon.picked_value, 'x);
        end else begin
          want = picks_due.pop_front();
          if (res_mon.picked_value !== want)
            report_mismatch("wrong value", res_mon.picked_value, want);
        end
      end
      if (req_mon.valid && req_mon.ready)
        picks_due.push_back(next_pick(req_mon.lower_bound, req_mon.upper_bound,
                                      req_mon.seed_start, req_mon.seed_offset));
    end
    picks_outstanding <= picks_due.size();
    pick_errors       <= mismatches;
  end

endmodule
`default_nettype wire

@@ dv/tb_lcg_range_permutation.sv @@
`default_nettype none
module tb_lcg_range_permutation;

  localparam int VB = lrp_pkg::VALUE_BITS;
  localparam int SB = lrp_pkg::SEED_BITS;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  localparam int VMAX = (1 << VB) - 1;
  localparam logic [SB-1:0] SEED_ONES = '1;

  logic clk;
  logic rst;
  int   pick_errors;
  int   picks_outstanding;
  int   sent = 0;
  int   burst_left = 0;
  bit   hold_off_due = 1'b0;
  bit   drained_once = 1'b0;

  lrp_req_if req_ch ();
  lrp_res_if res_ch ();

  lcg_range_permutation uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  lrp_pick_check checker_i (
    .clk               (clk),
    .rst               (rst),
    .req_mon           (req_ch),
    .res_mon           (res_ch),
    .pick_errors       (pick_errors),
    .picks_outstanding (picks_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SB-1:0] rand_seed();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SEED_ONES;
      default: return SB'($urandom);
    endcase
  endfunction

  // offers a request; returns at a falling edge after it is taken and any burst-end gap
  task automatic offer(input logic [VB-1:0] lo, input logic [VB-1:0] hi,
                       input logic [SB-1:0] ss, input logic [SB-1:0] so);
    req_ch.lower_bound = lo;
    req_ch.upper_bound = hi;
    req_ch.seed_start  = ss;
    req_ch.seed_offset = so;
    req_ch.valid       = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // a third of the bursts run straight into the next one
      if ($urandom_range(0, 2) != 0) begin
        req_ch.valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic wait_drained();
    while (picks_outstanding != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic directed();
    offer(0, 1, 0, 0);
    offer(0, 1, SEED_ONES, SEED_ONES);
    // inverted and empty ranges collapse to 0..1
    offer(100, 5, 12345, 678);
    offer(100, 5, 3, 9);
    offer(7, 7, SEED_ONES, 0);
    offer(0, 0, 1, 1);
    offer(VB'(VMAX), VB'(VMAX), 0, SEED_ONES);
    offer(VB'(VMAX - 1), VB'(VMAX), 1, 1);
    offer(VB'(VMAX - 1), VB'(VMAX), 0, 0);
    // power-of-two count with the start index landing on the count
    offer(16, 24, 8, 0);
    repeat (3) offer(16, 24, rand_seed(), rand_seed());
    offer(0, 4, 4, 3);
    offer(0, 2, 2, 1);
    offer(1000, 1003, 3, 2);
    offer(0, 32768, 32768, SEED_ONES);
    repeat (2) offer(0, 32768, rand_seed(), rand_seed());
    repeat (3) offer(0, VB'(VMAX), SEED_ONES, SEED_ONES);
    offer(0, 32769, 0, 0);
  endtask

  // a run of requests sharing one pair of bounds, so the shuffle gets walked
  task automatic random_run();
    int            kind;
    int            cnt;
    int            reps;
    logic [VB-1:0] lo;
    logic [VB-1:0] hi;
    logic [SB-1:0] ss;
    kind = $urandom_range(0, 99);
    if (kind < 45)      cnt = $urandom_range(1, 64);
    else if (kind < 70) cnt = $urandom_range(65, 4096);
    else if (kind < 80) cnt = $urandom_range(4097, VMAX);
    else if (kind < 88) cnt = 1 << $urandom_range(0, VB - 1);
    else                cnt = -1;
    if (cnt < 0) begin
      lo = VB'($urandom);
      hi = ($urandom_range(0, 3) == 0) ? lo : VB'($urandom);
    end else begin
      lo = VB'($urandom_range(0, VMAX - cnt));
      hi = VB'(int'(lo) + cnt);
    end
    ss = (cnt > 0 && $urandom_range(0, 3) == 0) ? SB'(cnt) : rand_seed();
    reps = $urandom_range(1, 12);
    offer(lo, hi, ss, rand_seed());
    repeat (reps - 1) offer(lo, hi, rand_seed(), rand_seed());
  endtask

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.lower_bound = '0;
    req_ch.upper_bound = '0;
    req_ch.seed_start  = '0;
    req_ch.seed_offset = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed();
    while (sent < 550) begin
      random_run();
      if (sent >= 150 && !hold_off_due) begin
        hold_off_due = 1'b1;
      end
      if (sent >= 350 && !drained_once) begin
        drained_once = 1'b1;
        req_ch.valid = 1'b0;
        wait_drained();
      end
    end
    req_ch.valid = 1'b0;
    while (picks_outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (pick_errors == 0 && picks_outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    rx_mode_t mode;
    int       span;
    bit       hold_done;
    hold_done    = 1'b0;
    res_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_off_due && !hold_done) begin
        hold_done    = 1'b1;
        res_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(10, 150);
      repeat (span) begin
        case (mode)
          RX_OPEN:  res_ch.ready = 1'b1;
          RX_COIN:  res_ch.ready = 1'($urandom_range(0, 1));
          default:  res_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    #2_000_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/lrp_pkg.sv
src/lrp_req_if.sv
src/lrp_res_if.sv
src/lcg_range_permutation.sv
src/lrp_checker.sv
dv/lrp_pick_check.sv
dv/tb_lcg_range_permutation.sv
